FILE: hdl/pbnfa_pkg.sv
// Shared types and constants for the next-fit page bitmap allocator.
// No dependencies; used by page_bitmap_next_fit_allocator.
package pbnfa_pkg;

    localparam int CFG_W       = 14;
    localparam int SIZE_W      = 26;
    localparam int ALIGN_W     = 4;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    // page counts, run lengths and page sums all stay below 2^27
    localparam int CALC_W      = 28;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_MISALIGN = 3'd2,
        STAT_KERNEL   = 3'd3,
        STAT_SMALL    = 3'd4,
        STAT_RANGE    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_MARK,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/page_bitmap_next_fit_allocator.sv
// Next-fit page allocator: one used bit per page in a simple dual-port bitmap memory,
// probed one page per cycle by a small sequencer. Depends on pbnfa_pkg.
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid/s_axis_tready     tuser: mode; tdata: size, align, free addr
// m_axis    out  m_axis_tvalid/m_axis_tready     tdata: base_addr, status
// cfg       in   i_cfg_wr_en                     i_cfg_wr_data: page_count
//
// Allocate: probing costs one bitmap read per cycle and visits each page at most once over both
//   passes; the pages of the run that it finds are then marked used.
// Free: clears the freed pages, one bitmap write per cycle; a failed check writes no page.
// After reset an init pass marks kernel pages used and the rest free; no transaction is taken.
// One transaction at a time; a finished result waits in the output register while the
//   next transaction is accepted, and the block holds in its last state if that register is full.
module page_bitmap_next_fit_allocator #(
    parameter int PAGE_TOTAL   = 8192,
    parameter int KERNEL_PAGES = 4096,
    parameter int PAGE_BITS    = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pbnfa_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [25:0] size_bytes, [29:26] align_log2, [61:30] free_addr, [63:62] zero
    input  logic [pbnfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] base_addr, [34:32] status, [39:35] zero
    output logic [pbnfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int PW  = $clog2(PAGE_TOTAL);
    localparam int AW  = pbnfa_pkg::CALC_W;
    localparam int PCW = (PW + 1 > pbnfa_pkg::CFG_W) ? PW + 1 : pbnfa_pkg::CFG_W;
    localparam int BW  = PW + PAGE_BITS;
    localparam logic [AW-1:0] PG_MASK   = AW'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [AW-1:0] TOTAL_A   = AW'(PAGE_TOTAL);
    localparam logic [AW-1:0] KERNEL_A  = AW'(KERNEL_PAGES);

    function automatic logic [AW-1:0] f_align_up(input logic [AW-1:0] x, input logic [AW-1:0] m);
        return (x + m) & ~m;
    endfunction

    pbnfa_pkg::t_state r_state, n_state;

    logic                       r_mem [PAGE_TOTAL];
    logic                       r_rd;
    logic                       w_we;
    logic                       w_bit;
    logic [PW-1:0]              w_addr;

    logic [PCW-1:0]             r_page_count;
    logic [PW-1:0]              r_last, n_last;
    logic [AW-1:0]              r_ptr, n_ptr;

    logic                       r_mode, n_mode;
    logic                       r_misal, n_misal;
    logic [AW-1:0]              r_cnt, n_cnt;
    logic [AW-1:0]              r_pfn, n_pfn;
    logic [AW-1:0]              r_amask, n_amask;
    logic [AW-1:0]              r_i, n_i;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_len, n_len;
    logic [AW-1:0]              r_hi, n_hi;
    logic [AW-1:0]              r_end, n_end;
    logic                       r_pass, n_pass;
    logic [pbnfa_pkg::ADDR_W-1:0] r_res_base, n_res_base;
    pbnfa_pkg::t_status         r_res_status, n_res_status;

    logic                       r_out_valid, n_out_valid;
    logic [pbnfa_pkg::ADDR_W-1:0] r_out_base, n_out_base;
    pbnfa_pkg::t_status         r_out_status, n_out_status;

    logic [AW-1:0]              n_eff;
    logic [AW-1:0]              hi_wrap;
    logic [AW-1:0]              in_size;
    logic [pbnfa_pkg::ADDR_W-1:0] in_addr;
    logic [pbnfa_pkg::ALIGN_W-1:0] in_align;
    logic [BW-1:0]              base_full;

    assign n_eff    = (AW'(r_page_count) < TOTAL_A) ? AW'(r_page_count) : TOTAL_A;
    assign hi_wrap  = (AW'(r_last) < n_eff - AW'(1)) ? AW'(r_last) : n_eff - AW'(1);
    assign in_size  = AW'(s_axis_tdata[pbnfa_pkg::SIZE_W-1:0]);
    assign in_align = s_axis_tdata[29:26];
    assign in_addr  = s_axis_tdata[61:30];
    assign base_full = BW'(r_i[PW-1:0]) << PAGE_BITS;

    assign s_axis_tready = (r_state == pbnfa_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_status, r_out_base};

    always_comb begin
        n_state      = r_state;
        n_last       = r_last;
        n_ptr        = r_ptr;
        n_mode       = r_mode;
        n_misal      = r_misal;
        n_cnt        = r_cnt;
        n_pfn        = r_pfn;
        n_amask      = r_amask;
        n_i          = r_i;
        n_idx        = r_idx;
        n_len        = r_len;
        n_hi         = r_hi;
        n_end        = r_end;
        n_pass       = r_pass;
        n_res_base   = r_res_base;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_base   = r_out_base;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_bit        = 1'b0;
        w_addr       = r_ptr[PW-1:0];

        unique case (r_state) inside
            pbnfa_pkg::ST_INIT: begin
                w_we  = 1'b1;
                w_bit = (r_ptr < KERNEL_A);
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == TOTAL_A - AW'(1)) begin
                    n_state = pbnfa_pkg::ST_IDLE;
                end
            end
            pbnfa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_cnt   = s_axis_tuser ? (in_size >> PAGE_BITS)
                                           : ((in_size + PG_MASK) >> PAGE_BITS);
                    n_pfn   = AW'(in_addr >> PAGE_BITS);
                    n_misal = (AW'(in_addr) & PG_MASK) != '0;
                    n_amask = (AW'(1) << in_align) - AW'(1);
                    n_state = pbnfa_pkg::ST_START;
                end
            end
            pbnfa_pkg::ST_START: begin
                n_res_base   = '0;
                n_res_status = pbnfa_pkg::STAT_OK;
                if (!r_mode) begin
                    if (r_cnt == '0 || n_eff == '0) begin
                        n_res_status = pbnfa_pkg::STAT_NOSPACE;
                        n_state      = pbnfa_pkg::ST_DONE;
                    end else begin
                        n_pass  = 1'b0;
                        n_hi    = n_eff - AW'(1);
                        n_i     = f_align_up(AW'(r_last) + AW'(1), r_amask);
                        n_idx   = n_i;
                        n_len   = '0;
                        n_state = pbnfa_pkg::ST_SEARCH;
                    end
                end else if (r_misal) begin
                    n_res_status = pbnfa_pkg::STAT_MISALIGN;
                    n_state      = pbnfa_pkg::ST_DONE;
                end else if (r_pfn < KERNEL_A) begin
                    n_res_status = pbnfa_pkg::STAT_KERNEL;
                    n_state      = pbnfa_pkg::ST_DONE;
                end else if (r_cnt == '0) begin
                    n_res_status = pbnfa_pkg::STAT_SMALL;
                    n_state      = pbnfa_pkg::ST_DONE;
                end else if (r_pfn + r_cnt > n_eff) begin
                    n_res_status = pbnfa_pkg::STAT_RANGE;
                    n_state      = pbnfa_pkg::ST_DONE;
                end else begin
                    n_ptr   = r_pfn;
                    n_end   = r_pfn + r_cnt;
                    n_state = pbnfa_pkg::ST_CLEAR;
                end
            end
            pbnfa_pkg::ST_SEARCH: begin
                if (r_idx > r_hi) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_hi   = hi_wrap;
                        n_i    = '0;
                        n_idx  = '0;
                        n_len  = '0;
                    end else begin
                        n_res_status = pbnfa_pkg::STAT_NOSPACE;
                        n_state      = pbnfa_pkg::ST_DONE;
                    end
                end else if (r_rd) begin
                    n_i   = f_align_up(r_idx + AW'(1), r_amask);
                    n_idx = n_i;
                    n_len = '0;
                end else if (r_len + AW'(1) == r_cnt) begin
                    n_ptr      = r_i;
                    n_end      = r_i + r_cnt;
                    n_last     = PW'(r_i + r_cnt - AW'(1));
                    n_res_base = pbnfa_pkg::ADDR_W'(base_full);
                    n_state    = pbnfa_pkg::ST_MARK;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_len = r_len + AW'(1);
                end
            end
            pbnfa_pkg::ST_MARK, pbnfa_pkg::ST_CLEAR: begin
                w_we  = 1'b1;
                w_bit = (r_state == pbnfa_pkg::ST_MARK);
                n_ptr = r_ptr + AW'(1);
                if (r_ptr + AW'(1) == r_end) begin
                    n_state = pbnfa_pkg::ST_DONE;
                end
            end
            pbnfa_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_base   = r_res_base;
                    n_out_status = r_res_status;
                    n_state      = pbnfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbnfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_bit;
        end
        r_rd <= r_mem[n_idx[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pbnfa_pkg::ST_INIT;
            r_ptr        <= '0;
            r_last       <= '0;
            r_page_count <= PCW'(PAGE_TOTAL);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_last       <= n_last;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_page_count <= PCW'(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_misal      <= n_misal;
        r_cnt        <= n_cnt;
        r_pfn        <= n_pfn;
        r_amask      <= n_amask;
        r_i          <= n_i;
        r_idx        <= n_idx;
        r_len        <= n_len;
        r_hi         <= n_hi;
        r_end        <= n_end;
        r_pass       <= n_pass;
        r_res_base   <= n_res_base;
        r_res_status <= n_res_status;
        r_out_base   <= n_out_base;
        r_out_status <= n_out_status;
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transaction accepted while previous one in progress");

    a_run_tracks_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbnfa_pkg::ST_SEARCH) |-> (r_idx == r_i + r_len))
        else $error("run length out of step with probe index");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbnfa_pkg::ST_SEARCH) |-> (r_hi < n_eff))
        else $error("search bound beyond present pages");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbnfa_pkg::ST_MARK || r_state == pbnfa_pkg::ST_CLEAR)
        |-> (r_ptr < r_end && r_end <= n_eff))
        else $error("bitmap write outside present pages");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbnfa_pkg::ST_DONE && $past(r_state) == pbnfa_pkg::ST_DONE)
        |-> $past(r_out_valid && !m_axis_tready))
        else $error("result held without a full output register");

endmodule

FILE: bench/page_bitmap_next_fit_allocator_test.sv
// Self-checking bench for page_bitmap_next_fit_allocator: streams allocate and free transactions,
// predicts every response from a bitmap model kept here and compares it field by field.
// Depends on pbnfa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module page_bitmap_next_fit_allocator_test;

    localparam int PAGE_TOTAL   = 8192;
    localparam int KERNEL_PAGES = 4096;
    localparam int PAGE_BITS    = 12;
    localparam longint PAGE_SIZE = longint'(1) << PAGE_BITS;
    localparam bit MODE_ALLOC   = 1'b0;
    localparam bit MODE_FREE    = 1'b1;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 200000;
    localparam int SIZE_W       = pbnfa_pkg::SIZE_W;
    localparam int ALIGN_W      = pbnfa_pkg::ALIGN_W;
    localparam int ADDR_W       = pbnfa_pkg::ADDR_W;
    localparam int CFG_W        = pbnfa_pkg::CFG_W;
    localparam bit [SIZE_W-1:0] SIZE_MAX = '1;

    typedef struct {
        bit               mode;
        bit [SIZE_W-1:0]  size_bytes;
        bit [ALIGN_W-1:0] align_log2;
        bit [ADDR_W-1:0]  free_addr;
    } t_page_req;

    typedef struct {
        bit [ADDR_W-1:0]    base_addr;
        pbnfa_pkg::t_status status;
    } t_page_resp;

    typedef struct {
        longint first_page;
        longint pages;
    } t_page_run;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [25:0] size_bytes, [29:26] align_log2, [61:30] free_addr, [63:62] zero
    logic [pbnfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] mode
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] base_addr, [34:32] status, [39:35] zero
    logic [pbnfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // allocator model state
    bit        used_page [PAGE_TOTAL];
    longint    last_end_page;
    longint    page_count_reg;

    t_page_req  pending_reqs[$];
    t_page_resp expected_results[$];
    t_page_run  live_runs[$];
    t_page_req  held_req;
    t_page_resp want;

    int requests_accepted = 0;
    int results_seen = 0;
    int alloc_count = 0;
    int alloc_granted = 0;
    int free_count = 0;
    int cfg_writes = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_started = 1'b0;
    int stall_cycles = 0;

    page_bitmap_next_fit_allocator #(
        .PAGE_TOTAL   (PAGE_TOTAL),
        .KERNEL_PAGES (KERNEL_PAGES),
        .PAGE_BITS    (PAGE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint align_up(longint x, longint a);
        return (x + a - 1) & ~(a - 1);
    endfunction

    function automatic bit find_free_run(longint cnt, longint lo, longint hi, longint a,
                                         output longint found);
        longint i;
        longint idx;
        bit hit;
        i = align_up(lo, a);
        while (i <= hi) begin
            hit = 1'b1;
            for (longint k = 0; k < cnt; k++) begin
                idx = i + k;
                if (idx > hi || idx >= PAGE_TOTAL)
                    return 1'b0;
                if (used_page[idx]) begin
                    i = align_up(idx + 1, a);
                    hit = 1'b0;
                    break;
                end
            end
            if (hit) begin
                found = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_response(t_page_req r);
        longint n, cnt, a, run_start, hi, pfn;
        bit ok;
        t_page_resp res;
        res.base_addr = '0;
        n = (page_count_reg < PAGE_TOTAL) ? page_count_reg : PAGE_TOTAL;
        if (r.mode == MODE_ALLOC) begin
            alloc_count++;
            cnt = (longint'(r.size_bytes) + PAGE_SIZE - 1) >> PAGE_BITS;
            a = longint'(1) << r.align_log2;
            ok = 1'b0;
            if (cnt != 0 && n != 0) begin
                ok = find_free_run(cnt, last_end_page + 1, n - 1, a, run_start);
                if (!ok) begin
                    hi = (last_end_page < n - 1) ? last_end_page : n - 1;
                    ok = find_free_run(cnt, 0, hi, a, run_start);
                end
            end
            if (ok) begin
                for (longint k = 0; k < cnt; k++)
                    used_page[run_start + k] = 1'b1;
                last_end_page = run_start + cnt - 1;
                res.base_addr = ADDR_W'(run_start << PAGE_BITS);
                res.status = pbnfa_pkg::STAT_OK;
                live_runs.push_back('{run_start, cnt});
                alloc_granted++;
            end else begin
                res.status = pbnfa_pkg::STAT_NOSPACE;
            end
        end else begin
            free_count++;
            pfn = longint'(r.free_addr) >> PAGE_BITS;
            cnt = longint'(r.size_bytes) >> PAGE_BITS;
            if (r.free_addr[PAGE_BITS-1:0] != '0) begin
                res.status = pbnfa_pkg::STAT_MISALIGN;
            end else if (pfn < KERNEL_PAGES) begin
                res.status = pbnfa_pkg::STAT_KERNEL;
            end else if (cnt == 0) begin
                res.status = pbnfa_pkg::STAT_SMALL;
            end else if (pfn + cnt > n) begin
                res.status = pbnfa_pkg::STAT_RANGE;
            end else begin
                for (longint k = 0; k < cnt; k++)
                    used_page[pfn + k] = 1'b0;
                res.status = pbnfa_pkg::STAT_OK;
            end
        end
        expected_results.push_back(res);
    endfunction

    // log-spread byte count so that every size bit shows up without many huge requests
    function automatic bit [SIZE_W-1:0] spread_size();
        return SIZE_W'($urandom) >> $urandom_range(0, SIZE_W - 1);
    endfunction

    function automatic t_page_req random_request(bit fill_mode);
        t_page_req r;
        t_page_run run;
        int roll;
        int idx;
        r.mode = MODE_ALLOC;
        r.size_bytes = SIZE_W'($urandom_range(1, 32'(16 * PAGE_SIZE)));
        r.align_log2 = ALIGN_W'($urandom_range(0, 2));
        r.free_addr = ADDR_W'($urandom);
        roll = $urandom_range(0, 99);
        if (fill_mode) begin
            if (roll < 70) begin
                r.size_bytes = SIZE_W'($urandom_range(1, 32'(6 * PAGE_SIZE)));
                r.align_log2 = ALIGN_W'($urandom_range(0, 1));
            end else begin
                r.mode = MODE_FREE;
                r.free_addr = ADDR_W'($urandom_range(KERNEL_PAGES, KERNEL_PAGES + 31))
                              << PAGE_BITS;
                r.size_bytes = SIZE_W'($urandom_range(0, 32'(8 * PAGE_SIZE)));
            end
        end else if (roll < 45) begin
            if (roll < 3)
                r.size_bytes = '0;
            else if (roll < 6)
                r.size_bytes = spread_size();
            if (roll >= 30)
                r.align_log2 = ALIGN_W'($urandom_range(0, 15));
        end else if (roll < 80 && live_runs.size() != 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            r.mode = MODE_FREE;
            r.free_addr = ADDR_W'(run.first_page << PAGE_BITS);
            if (run.pages > 1 && $urandom_range(0, 3) == 0)
                run.pages = longint'($urandom_range(1, 32'(run.pages - 1)));
            r.size_bytes = SIZE_W'((run.pages << PAGE_BITS) |
                                   longint'($urandom_range(0, 32'(PAGE_SIZE - 1))));
            r.align_log2 = ALIGN_W'($urandom);
        end else begin
            r.mode = 1'($urandom_range(0, 1));
            r.size_bytes = spread_size();
            r.align_log2 = ALIGN_W'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 0)
                r.free_addr = ADDR_W'($urandom_range(0, PAGE_TOTAL - 1)) << PAGE_BITS;
        end
        return r;
    endfunction

    task automatic queue_request(bit mode, bit [SIZE_W-1:0] size_bytes,
                                 bit [ALIGN_W-1:0] align_log2, bit [ADDR_W-1:0] free_addr);
        t_page_req r;
        r.mode = mode;
        r.size_bytes = size_bytes;
        r.align_log2 = align_log2;
        r.free_addr = free_addr;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_page_count(bit [CFG_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        page_count_reg = value;
        cfg_writes++;
    endtask

    task automatic run_random(int count, bit fill_mode);
        int queued;
        queued = 0;
        while (queued < count) begin
            @(negedge i_clk);
            if (pending_reqs.size() < 2) begin
                pending_reqs.push_back(random_request(fill_mode));
                queued++;
            end
        end
    endtask

    // driver: load the next request once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_response(held_req);
                requests_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 &&
                    ((requests_accepted >= 400 && requests_accepted < 470) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held_req = pending_reqs.pop_front();
                    s_axis_tdata <= {2'b00, held_req.free_addr, held_req.align_log2,
                                     held_req.size_bytes};
                    s_axis_tuser <= held_req.mode;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each response with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected response: base_addr 0x%08h status %0d",
                           m_axis_tdata[31:0], m_axis_tdata[34:32]);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.base_addr) begin
                        $error("base_addr mismatch: expected 0x%08h, actual 0x%08h",
                               want.base_addr, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[34:32] !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tdata[34:32]);
                        errors++;
                    end
                end
            end
            if (!hold_started && results_seen >= 150) begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (results_seen >= 400 && results_seen < 470) ||
                                 $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < PAGE_TOTAL; k++)
            used_page[k] = (k < KERNEL_PAGES);
        last_end_page = 0;
        page_count_reg = PAGE_TOTAL;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_page_count(CFG_W'(PAGE_TOTAL));
        queue_request(MODE_ALLOC, '0, '0, '0);
        queue_request(MODE_ALLOC, SIZE_W'(1), '0, '0);
        queue_request(MODE_ALLOC, SIZE_W'(PAGE_SIZE), '0, '0);
        queue_request(MODE_ALLOC, SIZE_W'(PAGE_SIZE + 1), '0, '0);
        queue_request(MODE_ALLOC, SIZE_W'(3 * PAGE_SIZE), ALIGN_W'(4), '0);
        queue_request(MODE_ALLOC, SIZE_MAX, '0, '0);
        queue_request(MODE_ALLOC, SIZE_W'(PAGE_SIZE), ALIGN_W'(13), '0);
        queue_request(MODE_ALLOC, SIZE_W'(PAGE_SIZE), ALIGN_W'(15), '1);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'h0100_0001);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '1, 32'hFFFF_FFFF);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'h0000_0000);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'h00FF_F000);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE - 1), '0, 32'h0FFF_F000);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'hFFFF_F000);
        queue_request(MODE_FREE, SIZE_W'(2 * PAGE_SIZE - 1), '0, 32'h0100_0000);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'h0100_0000);
        queue_request(MODE_FREE, SIZE_MAX, '0, 32'h0100_0000);
        queue_request(MODE_FREE, SIZE_W'(PAGE_SIZE), '0, 32'h01FF_F000);
        queue_request(MODE_FREE, SIZE_W'(2 * PAGE_SIZE), '0, 32'h01FF_F000);
        queue_request(MODE_ALLOC, SIZE_W'(2 * PAGE_SIZE), '0, '0);
        run_random(280, 1'b0);

        write_page_count('1);
        run_random(150, 1'b0);
        write_page_count(CFG_W'(KERNEL_PAGES + 32));
        run_random(50, 1'b1);
        write_page_count(CFG_W'(1));
        run_random(10, 1'b0);
        write_page_count('0);
        run_random(10, 1'b0);
        write_page_count(CFG_W'(6000));
        run_random(150, 1'b0);

        wait_idle();
        repeat (32) @(posedge i_clk);
        $display("Checked %0d responses: %0d allocations (%0d granted) and %0d frees,",
                 results_seen, alloc_count, alloc_granted, free_count);
        $display("over %0d page_count settings including 0, 1, 4128 and saturation.",
                 cfg_writes);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
hdl/pbnfa_pkg.sv
hdl/page_bitmap_next_fit_allocator.sv
bench/page_bitmap_next_fit_allocator_test.sv
